// ===== hw/rtl/dltq_pkg.sv =====
// ----------------------------------------------------------------------------
// dltq_pkg
// Shared constants, status codes and beat types of the delta list timer queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dltq_pkg;

  localparam int SLOTS = 16;
  localparam int DUR_W = 16;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);

  localparam logic FUNC_SET  = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  localparam logic [1:0] ST_SET_OK  = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NO_EXP  = 2'd2;
  localparam logic [1:0] ST_EXPIRED = 2'd3;

  typedef struct packed {
    logic        func;
    logic [7:0]  timer_id;
    logic [15:0] duration;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  expired_id;
    logic [15:0] head_remaining;
    logic [4:0]  pending;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic             we_id;
    logic             we_dl;
    logic [IDX_W-1:0] addr;
    logic [7:0]       id;
    logic [DUR_W-1:0] delta;
  } mem_wr_t;

  typedef struct packed {
    logic [7:0]       id;
    logic [DUR_W-1:0] delta;
  } mem_rd_t;

endpackage

// ===== hw/rtl/delta_list_timer_queue.sv =====
// ----------------------------------------------------------------------------
// delta_list_timer_queue
// Bounded timer queue kept as a sorted delta list, with a registered output.
// ----------------------------------------------------------------------------
// One item is handled at a time, one list entry per step through an entry
// memory with one write and one registered read a cycle. A set walks past
// the entries due no later than it, shifts the later entries back and
// writes the new one; a set on a full queue leaves the list untouched and a
// tick that expires nothing only decrements the head delta. A tick with
// expiry pops each expired timer in turn, shifting the rest forward, and
// emits a beat for each. The result beat waits in an output register, so the
// queue goes on once a beat is stored, and stalls only while that register is
// still full.
`timescale 1ns / 1ps

module delta_list_timer_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  dltq_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output dltq_pkg::rsp_t rsp
);

  dltq_pkg::mem_wr_t          wr;
  dltq_pkg::mem_rd_t          rdata;
  logic [dltq_pkg::IDX_W-1:0] raddr;
  logic                       emit_valid;
  logic                       emit_ready;
  dltq_pkg::rsp_t             emit_data;

  assign emit_ready = !rsp_valid || rsp_ready;

  dltq_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .emit_valid (emit_valid),
    .emit_ready (emit_ready),
    .emit_data  (emit_data),
    .wr         (wr),
    .raddr      (raddr),
    .rdata      (rdata)
  );

  dltq_store u_store (
    .clk   (clk),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (emit_ready) begin
      rsp_valid <= emit_valid;
    end
    if (emit_valid && emit_ready) begin
      rsp <= emit_data;
    end
  end

endmodule

// ===== hw/rtl/dltq_store.sv =====
// ----------------------------------------------------------------------------
// dltq_store
// Entry memory: timer ids and deltas, one write and one registered read a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dltq_store (
  input  logic                            clk,
  input  dltq_pkg::mem_wr_t               wr,
  input  logic [dltq_pkg::IDX_W-1:0]      raddr,
  output dltq_pkg::mem_rd_t               rdata
);

  logic [7:0]                 ids [dltq_pkg::SLOTS];
  logic [dltq_pkg::DUR_W-1:0] dls [dltq_pkg::SLOTS];

  always_ff @(posedge clk) begin
    if (wr.we_id) begin
      ids[wr.addr] <= wr.id;
    end
    if (wr.we_dl) begin
      dls[wr.addr] <= wr.delta;
    end
    rdata.id    <= ids[raddr];
    rdata.delta <= dls[raddr];
  end

endmodule

// ===== hw/rtl/dltq_seq.sv =====
// ----------------------------------------------------------------------------
// dltq_seq
// Sequencer: walks, shifts and pops the delta list one entry at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dltq_seq (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  dltq_pkg::req_t              req,
  output logic                        emit_valid,
  input  logic                        emit_ready,
  output dltq_pkg::rsp_t              emit_data,
  output dltq_pkg::mem_wr_t           wr,
  output logic [dltq_pkg::IDX_W-1:0]  raddr,
  input  dltq_pkg::mem_rd_t           rdata
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_WALK_RD  = 4'd1;
  localparam logic [3:0] S_WALK_CMP = 4'd2;
  localparam logic [3:0] S_INS_RD   = 4'd3;
  localparam logic [3:0] S_INS_WR   = 4'd4;
  localparam logic [3:0] S_INS_PUT  = 4'd5;
  localparam logic [3:0] S_POP_RD   = 4'd6;
  localparam logic [3:0] S_POP_ID   = 4'd7;
  localparam logic [3:0] S_POP_SRD  = 4'd8;
  localparam logic [3:0] S_POP_SWR  = 4'd9;
  localparam logic [3:0] S_EMIT     = 4'd10;

  logic [3:0]                 state, state_next;
  logic [dltq_pkg::CNT_W-1:0] count, count_next;
  logic [dltq_pkg::DUR_W-1:0] head, head_next;
  logic [dltq_pkg::IDX_W-1:0] pos, pos_next;
  logic [dltq_pkg::CNT_W-1:0] idx, idx_next;
  logic [dltq_pkg::DUR_W-1:0] rem, rem_next;
  logic [7:0]                 id_q, id_next;
  logic [1:0]                 st, st_next;

  logic [dltq_pkg::DUR_W-1:0] dec;
  logic                       more;

  assign dec  = (head == '0) ? '0 : head - 1'b1;
  assign more = (count != '0) && (head == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    head <= head_next;
    pos  <= pos_next;
    idx  <= idx_next;
    rem  <= rem_next;
    id_q <= id_next;
    st   <= st_next;
  end

  always_comb begin
    state_next = state;
    count_next = count;
    head_next  = head;
    pos_next   = pos;
    idx_next   = idx;
    rem_next   = rem;
    id_next    = id_q;
    st_next    = st;
    wr         = '0;
    raddr      = '0;
    emit_valid = 1'b0;
    emit_data  = '0;
    req_ready  = (state == S_IDLE);

    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          if (req.func == dltq_pkg::FUNC_SET) begin
            if (count == dltq_pkg::CNT_W'(dltq_pkg::SLOTS)) begin
              st_next    = dltq_pkg::ST_FULL;
              state_next = S_EMIT;
            end else begin
              id_next    = req.timer_id;
              rem_next   = req.duration[dltq_pkg::DUR_W-1:0];
              pos_next   = '0;
              state_next = S_WALK_RD;
            end
          end else if (count == '0) begin
            st_next    = dltq_pkg::ST_NO_EXP;
            state_next = S_EMIT;
          end else begin
            // saturating decrement of the head delta
            wr.we_dl = 1'b1;
            wr.addr  = '0;
            wr.delta = dec;
            if (dec != '0) begin
              st_next    = dltq_pkg::ST_NO_EXP;
              state_next = S_EMIT;
            end else begin
              state_next = S_POP_RD;
            end
          end
        end
      end
      S_WALK_RD: begin
        if (dltq_pkg::CNT_W'(pos) == count) begin
          idx_next   = count;
          state_next = S_INS_RD;
        end else begin
          raddr      = pos;
          state_next = S_WALK_CMP;
        end
      end
      S_WALK_CMP: begin
        // pass entries due no later than the new timer, so ties keep set order
        if (rem >= rdata.delta) begin
          rem_next   = rem - rdata.delta;
          pos_next   = pos + 1'b1;
          state_next = S_WALK_RD;
        end else begin
          wr.we_dl   = 1'b1;
          wr.addr    = pos;
          wr.delta   = rdata.delta - rem;
          idx_next   = count;
          state_next = S_INS_RD;
        end
      end
      S_INS_RD: begin
        if (idx == dltq_pkg::CNT_W'(pos)) begin
          state_next = S_INS_PUT;
        end else begin
          raddr      = dltq_pkg::IDX_W'(idx - 1'b1);
          state_next = S_INS_WR;
        end
      end
      S_INS_WR: begin
        wr.we_id   = 1'b1;
        wr.we_dl   = 1'b1;
        wr.addr    = idx[dltq_pkg::IDX_W-1:0];
        wr.id      = rdata.id;
        wr.delta   = rdata.delta;
        idx_next   = idx - 1'b1;
        state_next = S_INS_RD;
      end
      S_INS_PUT: begin
        wr.we_id   = 1'b1;
        wr.we_dl   = 1'b1;
        wr.addr    = pos;
        wr.id      = id_q;
        wr.delta   = rem;
        count_next = count + 1'b1;
        st_next    = dltq_pkg::ST_SET_OK;
        state_next = S_EMIT;
      end
      S_POP_RD: begin
        raddr      = '0;
        state_next = S_POP_ID;
      end
      S_POP_ID: begin
        id_next    = rdata.id;
        idx_next   = dltq_pkg::CNT_W'(1);
        state_next = S_POP_SRD;
      end
      S_POP_SRD: begin
        if (idx == count) begin
          count_next = count - 1'b1;
          st_next    = dltq_pkg::ST_EXPIRED;
          state_next = S_EMIT;
        end else begin
          raddr      = idx[dltq_pkg::IDX_W-1:0];
          state_next = S_POP_SWR;
        end
      end
      S_POP_SWR: begin
        wr.we_id   = 1'b1;
        wr.we_dl   = 1'b1;
        wr.addr    = dltq_pkg::IDX_W'(idx - 1'b1);
        wr.id      = rdata.id;
        wr.delta   = rdata.delta;
        idx_next   = idx + 1'b1;
        state_next = S_POP_SRD;
      end
      S_EMIT: begin
        emit_valid                = 1'b1;
        emit_data.status          = st;
        emit_data.expired_id      = (st == dltq_pkg::ST_EXPIRED) ? id_q : 8'd0;
        emit_data.head_remaining  = (count == '0) ? 16'd0 : 16'(head);
        emit_data.pending         = 5'(count);
        emit_data.last            = (st == dltq_pkg::ST_EXPIRED) ? !more : 1'b1;
        if (emit_ready) begin
          state_next = (st == dltq_pkg::ST_EXPIRED && more) ? S_POP_RD : S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // keep a copy of slot 0's delta for the result beats
    if (wr.we_dl && wr.addr == '0) begin
      head_next = wr.delta;
    end
  end

endmodule

// ===== hw/rtl/dltq_checker.sv =====
// ----------------------------------------------------------------------------
// dltq_checker
// Port-level checks of the timer queue, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dltq_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input dltq_pkg::rsp_t rsp
);

  // only an expiry run spans several beats
  a_last_only_expiry: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.last |-> rsp.status == dltq_pkg::ST_EXPIRED)
    else $error("non-final beat without expiry status");

  a_id_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != dltq_pkg::ST_EXPIRED |-> rsp.expired_id == 8'd0)
    else $error("expired_id set on a non-expiry beat");

  a_empty_head: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.pending == 5'd0 |-> rsp.head_remaining == 16'd0)
    else $error("empty queue reports a head delta");

  // hold the result beat until it is taken
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response beat changed while waiting");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("next item taken before the current one finished");

endmodule

bind delta_list_timer_queue dltq_checker u_dltq_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
